// File: rtl/ksr_pkg.sv
// ksr_pkg: shared constants, codes, the fixed sequence table and the lookup result type
// used by ksr_lookup and keyed_sequence_responder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ksr_pkg;

    localparam int DATA_W  = 16;
    localparam int POS_W   = 6;
    localparam int KEY_W   = 6;
    localparam int KEY_LSB = 9;
    localparam int ENTRY_W = 8;
    localparam int SEQ_LEN = 57;

    // access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [ENTRY_W-1:0] SEQ_TABLE [SEQ_LEN] = '{
        8'h13, 8'h27, 8'h0f, 8'h1f, 8'h3e, 8'h3d, 8'h3b, 8'h37,
        8'h2e, 8'h1c, 8'h38, 8'h31, 8'h22, 8'h05, 8'h0a, 8'h15,
        8'h2b, 8'h16, 8'h2d, 8'h1a, 8'h34, 8'h28, 8'h10, 8'h21,
        8'h03, 8'h06, 8'h0c, 8'h19, 8'h32, 8'h24, 8'h09, 8'h13,
        8'h27, 8'h0f, 8'h1f, 8'h3e, 8'h3d, 8'h3b, 8'h37, 8'h2e,
        8'h1c, 8'h38, 8'h31, 8'h22, 8'h05, 8'h0a, 8'h15, 8'h2b,
        8'h16, 8'h2d, 8'h1a, 8'h34, 8'h28, 8'h10, 8'h21, 8'h03,
        8'hff
    };

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [POS_W-1:0]  next_pos;
    } t_lookup_res;

endpackage

`default_nettype wire

// File: rtl/ksr_lookup.sv
// ksr_lookup: combinational read/advance and key search for one request
// depends on ksr_pkg (table, widths, access codes, t_lookup_res)
`timescale 1ns / 1ps
`default_nettype none

module ksr_lookup
    import ksr_pkg::*;
(
    input  wire logic              i_func,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic [POS_W-1:0]  i_pos,
    output t_lookup_res            o_res
);

    logic [POS_W-1:0]   pos_eff;
    logic [ENTRY_W-1:0] entry;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   found;

    // past the table wraps to the start
    assign pos_eff = (i_pos >= POS_W'(SEQ_LEN)) ? '0 : i_pos;
    assign entry   = SEQ_TABLE[pos_eff];
    assign key     = i_write_data[KEY_LSB +: KEY_W];

    // priority search, lowest matching index wins
    always_comb begin
        found = '0;
        for (int i = SEQ_LEN - 1; i >= 0; i--) begin
            if (SEQ_TABLE[i] == {{(ENTRY_W-KEY_W){1'b0}}, key}) begin
                found = POS_W'(i);
            end
        end
    end

    always_comb begin
        case (i_func)
            FUNC_READ: begin
                o_res.read_data = DATA_W'({entry, {KEY_LSB{1'b0}}});
                o_res.next_pos  = pos_eff + POS_W'(1);
            end
            FUNC_WRITE: begin
                o_res.read_data = '0;
                o_res.next_pos  = found;
            end
            default: begin
                o_res.read_data = '0;
                o_res.next_pos  = i_pos;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/keyed_sequence_responder.sv
// keyed_sequence_responder: a request passes the input register, then the result register
// (lookup in between); throughput one request per cycle while the result channel is not
// stalled, set by the single lookup stage between the two registers and the position
// register it updates
// reset (synchronous, active low) clears the sequence position and both valid flags
// depends on ksr_pkg and ksr_lookup
`timescale 1ns / 1ps
`default_nettype none

module keyed_sequence_responder
    import ksr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_func,
    input  wire logic [DATA_W-1:0] i_write_data,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [DATA_W-1:0]      o_read_data
);

    // input register
    logic              r_req_valid, n_req_valid;
    logic              r_func;
    logic [DATA_W-1:0] r_write_data;

    // sequence position, updated as a request moves into the result register
    logic [POS_W-1:0]  r_pos, n_pos;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_read_data;

    logic        advance;
    logic        accept;
    t_lookup_res res;

    // the held request moves on when the result slot is empty or being drained
    assign advance    = r_req_valid && (!r_out_valid || !i_out_stall);
    // input side keeps taking requests unless a held one cannot move
    assign o_in_stall = r_req_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    ksr_lookup u_lookup (
        .i_func       (r_func),
        .i_write_data (r_write_data),
        .i_pos        (r_pos),
        .o_res        (res)
    );

    always_comb begin
        n_req_valid = r_req_valid;
        if (accept) begin
            n_req_valid = 1'b1;
        end else if (advance) begin
            n_req_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign n_pos = advance ? res.next_pos : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_req_valid <= n_req_valid;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func       <= i_func;
            r_write_data <= i_write_data;
        end
        if (advance) begin
            r_read_data <= res.read_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire
